[src/itp_pkg.sv]
// Shared types, codes and the precedence table of the infix to postfix converter.
package itp_pkg;

   localparam int DEFAULT_STACK_DEPTH = 16;

   localparam int KIND_W = 2;
   localparam int CODE_W = 5;
   localparam int TAG_W  = 16;
   localparam int PREC_W = 5;

   localparam int REQ_TDATA_W = 24;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 24;
   localparam int RSP_TUSER_W = 3;

   // input token kinds
   localparam logic [KIND_W-1:0] KIND_OPERAND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SPECIAL  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_BRACKET  = 2'd3;

   // result kinds
   localparam logic [KIND_W-1:0] OUT_OPERAND  = 2'd0;
   localparam logic [KIND_W-1:0] OUT_OPERATOR = 2'd1;
   localparam logic [KIND_W-1:0] OUT_END      = 2'd2;
   localparam logic [KIND_W-1:0] OUT_ERROR    = 2'd3;

   // operator codes
   localparam logic [CODE_W-1:0] OP_ASSIGN = 5'd0;
   localparam logic [CODE_W-1:0] OP_ADD    = 5'd1;
   localparam logic [CODE_W-1:0] OP_SUB    = 5'd2;
   localparam logic [CODE_W-1:0] OP_MUL    = 5'd3;
   localparam logic [CODE_W-1:0] OP_DIV    = 5'd4;
   localparam logic [CODE_W-1:0] OP_GT     = 5'd5;
   localparam logic [CODE_W-1:0] OP_GE     = 5'd6;
   localparam logic [CODE_W-1:0] OP_LT     = 5'd7;
   localparam logic [CODE_W-1:0] OP_LE     = 5'd8;
   localparam logic [CODE_W-1:0] OP_EQ     = 5'd9;
   localparam logic [CODE_W-1:0] OP_NE     = 5'd10;
   localparam logic [CODE_W-1:0] OP_LAND   = 5'd11;
   localparam logic [CODE_W-1:0] OP_LOR    = 5'd12;

   localparam logic [PREC_W-1:0] PREC_NONE   = 5'd0;
   localparam logic [PREC_W-1:0] PREC_ASSIGN = 5'd3;
   localparam logic [PREC_W-1:0] PREC_LOGIC  = 5'd10;
   localparam logic [PREC_W-1:0] PREC_EQUAL  = 5'd11;
   localparam logic [PREC_W-1:0] PREC_REL    = 5'd12;
   localparam logic [PREC_W-1:0] PREC_ADD    = 5'd13;
   localparam logic [PREC_W-1:0] PREC_MUL    = 5'd14;
   localparam logic [PREC_W-1:0] PREC_UNARY  = 5'd18;

   typedef struct packed {
      logic                unary;
      logic [CODE_W-1:0]   code;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_REDUCE,
      ST_REDUCE_WAIT,
      ST_PUSH,
      ST_FLUSH,
      ST_FLUSH_WAIT,
      ST_FINISH
   } state_type;

   typedef enum logic [2:0] {
      EMIT_NONE,
      EMIT_OPERAND,
      EMIT_TOP,
      EMIT_END,
      EMIT_ERROR
   } emit_type;

   typedef struct packed {
      logic       latch;
      emit_type   emit;
      logic       last;
      logic       pop;
      logic       push;
      logic       bracket;
      logic       clear;
   } ctl_type;

   typedef struct packed {
      logic                cmd;
      logic [KIND_W-1:0]   kind;
      logic                err;
      logic                unary;
      logic                empty;
      logic                top_ge;
      logic                next_ge;
      logic                out_free;
   } sts_type;

   function automatic logic [PREC_W-1:0] prec_of(input logic [CODE_W-1:0] code,
                                                 input logic unary);
      logic [PREC_W-1:0] p;
      p = PREC_NONE;
      if (unary) begin
         if (code == OP_ADD || code == OP_SUB) begin
            p = PREC_UNARY;
         end
      end else begin
         case (code)
            OP_ASSIGN:                 p = PREC_ASSIGN;
            OP_ADD, OP_SUB:            p = PREC_ADD;
            OP_MUL, OP_DIV:            p = PREC_MUL;
            OP_GT, OP_GE, OP_LT, OP_LE: p = PREC_REL;
            OP_EQ, OP_NE:              p = PREC_EQUAL;
            OP_LAND, OP_LOR:           p = PREC_LOGIC;
            default:                   p = PREC_NONE;
         endcase
      end
      return p;
   endfunction

endpackage

[src/infix_to_postfix_converter.sv]
// Top level of the shunting-yard infix to postfix converter.
// Takes one token or end command per beat and emits postfix beats; tlast marks
// the final beat caused by an input beat. One input beat is handled at a time:
// an operand is emitted, a unary operator pushed, a binary one first pops stacked
// operators while the top has greater or equal precedence, an end command pops
// all stacked operators before its end beat, or gives an error beat after an error,
// and a bracket or a dropped token gives no output. Pops are paced by the
// registered stack read, with a wait state after every pop. The result register
// lets a finished beat wait while the next input beat is taken.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [itp_pkg::REQ_TDATA_W-1:0] req_tdata,  // operator_code, operand_tag
   input  logic [itp_pkg::REQ_TUSER_W-1:0] req_tuser,  // command, token_kind
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [itp_pkg::RSP_TDATA_W-1:0] rsp_tdata,  // out_operator, out_operand
   output logic [itp_pkg::RSP_TUSER_W-1:0] rsp_tuser,  // out_kind, out_unary
   output logic                            rsp_tlast
);
   import itp_pkg::*;

   ctl_type ctl;
   sts_type sts;

   itp_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   itp_datapath #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .ctl        (ctl),
      .sts        (sts),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[src/itp_datapath.sv]
// Token registers, operator stack memory, state flags and the result register.
module itp_datapath #(
   parameter int STACK_DEPTH = itp_pkg::DEFAULT_STACK_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic [itp_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic [itp_pkg::REQ_TUSER_W-1:0] req_tuser,
   input  itp_pkg::ctl_type                ctl,
   output itp_pkg::sts_type                sts,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [itp_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic [itp_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   output logic                            rsp_tlast
);
   import itp_pkg::*;

   localparam int CW = $clog2(STACK_DEPTH + 1);
   localparam int AW = $clog2(STACK_DEPTH);

   entry_type           mem [STACK_DEPTH];

   logic                cmd_ff;
   logic [KIND_W-1:0]   kind_ff;
   logic [CODE_W-1:0]   code_ff;
   logic [TAG_W-1:0]    tag_ff;

   logic [CW-1:0]       cnt_ff, cnt_in;
   logic                prev_ff, prev_in;
   logic                err_ff, err_in;

   entry_type           top_ff;
   entry_type           next_ff;
   logic [CW-1:0]       top_idx;
   logic [CW-1:0]       next_idx;
   logic                full;
   logic [PREC_W-1:0]   in_prec;

   logic                vld_ff, vld_in;
   logic [KIND_W-1:0]   okind_ff, okind_in;
   logic [CODE_W-1:0]   oop_ff, oop_in;
   logic                ouny_ff, ouny_in;
   logic [TAG_W-1:0]    otag_ff, otag_in;
   logic                olast_ff, olast_in;

   assign top_idx  = cnt_ff - CW'(1);
   assign next_idx = cnt_ff - CW'(2);
   assign full     = (cnt_ff == CW'(STACK_DEPTH));
   assign in_prec  = prec_of(code_ff, 1'b0);

   always_ff @(posedge clock) begin
      if (ctl.latch) begin
         cmd_ff  <= req_tuser[0];
         kind_ff <= req_tuser[2:1];
         code_ff <= req_tdata[CODE_W-1:0];
         tag_ff  <= req_tdata[CODE_W+TAG_W-1:CODE_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.push && !full) begin
         mem[cnt_ff[AW-1:0]] <= '{unary: prev_ff, code: code_ff};
      end
      top_ff  <= mem[top_idx[AW-1:0]];
      next_ff <= mem[next_idx[AW-1:0]];
   end

   always_comb begin
      cnt_in  = cnt_ff;
      prev_in = prev_ff;
      err_in  = err_ff;
      if (ctl.clear) begin
         cnt_in  = '0;
         prev_in = 1'b1;
         err_in  = 1'b0;
      end else begin
         if (ctl.pop) begin
            cnt_in = cnt_ff - CW'(1);
         end
         if (ctl.push) begin
            if (full) begin
               err_in = 1'b1;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
            prev_in = (kind_ff == KIND_OPERATOR);
         end
         if (ctl.bracket) begin
            err_in = 1'b1;
         end
         if (ctl.emit == EMIT_OPERAND) begin
            prev_in = 1'b0;
         end
      end
   end

   always_comb begin
      vld_in   = vld_ff && !rsp_tready;
      okind_in = okind_ff;
      oop_in   = oop_ff;
      ouny_in  = ouny_ff;
      otag_in  = otag_ff;
      olast_in = olast_ff;
      if (ctl.emit != EMIT_NONE) begin
         vld_in   = 1'b1;
         oop_in   = '0;
         ouny_in  = 1'b0;
         otag_in  = '0;
         olast_in = ctl.last;
         case (ctl.emit)
            EMIT_OPERAND: begin
               okind_in = OUT_OPERAND;
               otag_in  = tag_ff;
            end
            EMIT_TOP: begin
               okind_in = OUT_OPERATOR;
               oop_in   = top_ff.code;
               ouny_in  = top_ff.unary;
            end
            EMIT_END:   okind_in = OUT_END;
            EMIT_ERROR: okind_in = OUT_ERROR;
            default:    okind_in = OUT_ERROR;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         prev_ff <= 1'b1;
         err_ff  <= 1'b0;
         vld_ff  <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         prev_ff <= prev_in;
         err_ff  <= err_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      okind_ff <= okind_in;
      oop_ff   <= oop_in;
      ouny_ff  <= ouny_in;
      otag_ff  <= otag_in;
      olast_ff <= olast_in;
   end

   always_comb begin
      sts.cmd      = cmd_ff;
      sts.kind     = kind_ff;
      sts.err      = err_ff;
      sts.unary    = prev_ff;
      sts.empty    = (cnt_ff == '0);
      sts.top_ge   = (prec_of(top_ff.code, top_ff.unary) >= in_prec);
      sts.next_ge  = (cnt_ff >= CW'(2)) && (prec_of(next_ff.code, next_ff.unary) >= in_prec);
      sts.out_free = !vld_ff || rsp_tready;
   end

   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = {{(RSP_TDATA_W - TAG_W - CODE_W){1'b0}}, otag_ff, oop_ff};
   assign rsp_tuser  = {ouny_ff, okind_ff};
   assign rsp_tlast  = olast_ff;

endmodule

[src/itp_controller.sv]
// Sequencer that steps each token through pop, push and emit phases.
module itp_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  itp_pkg::sts_type sts,
   output itp_pkg::ctl_type ctl
);
   import itp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      ctl        = '{latch: 1'b0, emit: EMIT_NONE, last: 1'b0, pop: 1'b0,
                     push: 1'b0, bracket: 1'b0, clear: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.latch = 1'b1;
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (sts.cmd) begin
               if (sts.err || sts.empty) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_FLUSH;
               end
            end else if (sts.err) begin
               state_in = ST_IDLE;
            end else if (sts.kind == KIND_OPERAND) begin
               state_in = ST_FINISH;
            end else if (sts.kind == KIND_BRACKET) begin
               ctl.bracket = 1'b1;
               state_in    = ST_IDLE;
            end else if (sts.unary) begin
               state_in = ST_PUSH;
            end else begin
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            if (!sts.empty && sts.top_ge) begin
               if (sts.out_free) begin
                  ctl.emit = EMIT_TOP;
                  ctl.last = !sts.next_ge;
                  ctl.pop  = 1'b1;
                  state_in = ST_REDUCE_WAIT;
               end
            end else begin
               state_in = ST_PUSH;
            end
         end
         ST_REDUCE_WAIT: state_in = ST_REDUCE;
         ST_PUSH: begin
            ctl.push = 1'b1;
            state_in = ST_IDLE;
         end
         ST_FLUSH: begin
            if (sts.out_free) begin
               ctl.emit = EMIT_TOP;
               ctl.pop  = 1'b1;
               state_in = ST_FLUSH_WAIT;
            end
         end
         ST_FLUSH_WAIT: begin
            state_in = sts.empty ? ST_FINISH : ST_FLUSH;
         end
         ST_FINISH: begin
            if (sts.out_free) begin
               ctl.last = 1'b1;
               if (sts.cmd) begin
                  ctl.emit  = sts.err ? EMIT_ERROR : EMIT_END;
                  ctl.clear = 1'b1;
               end else begin
                  ctl.emit = EMIT_OPERAND;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[dv/tb_infix_to_postfix_converter.sv]
// Self-checking testbench of the infix to postfix converter: directed table, then random.
module tb_infix_to_postfix_converter;
   timeunit 1ns;
   timeprecision 1ps;

   import itp_pkg::*;

   localparam int DEPTH          = DEFAULT_STACK_DEPTH;
   localparam int BEAT_TARGET    = 450;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 3 + 2 * DEPTH + 8;
   localparam int MAX_REPORTS    = 20;

   localparam logic CMD_TOKEN = 1'b0;
   localparam logic CMD_END   = 1'b1;

   typedef struct packed {
      logic                cmd;
      logic [KIND_W-1:0]   kind;
      logic [CODE_W-1:0]   code;
      logic [TAG_W-1:0]    tag;
   } token_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [CODE_W-1:0]   op;
      logic                unary;
      logic [TAG_W-1:0]    operand;
      logic                last;
   } postfix_type;

   typedef enum logic [1:0] {
      CHK_PREDICT,
      CHK_SILENT,
      CHK_ONE
   } row_check_type;

   typedef struct {
      token_type       tok;
      int              reps;
      row_check_type   check;
      postfix_type     want;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;   // operator_code, operand_tag
   logic [REQ_TUSER_W-1:0] req_tuser = '0;   // command, token_kind
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;        // out_operator, out_operand
   logic [RSP_TUSER_W-1:0] rsp_tuser;        // out_kind, out_unary
   logic                   rsp_tlast;

   // predictor state
   entry_type   shadow_stack [DEPTH];
   int          shadow_depth = 0;
   bit          shadow_expect_unary = 1'b1;
   bit          shadow_err = 1'b0;

   postfix_type postfix_expected [$];
   dir_row_type dir_rows [29];

   bit          calm = 1'b0;
   int          stall_left = 0;
   int          beats_taken = 0;
   int          errors = 0;
   int          n_checked = 0;
   int          n_exprs = 0;
   int          n_err_markers = 0;
   int          n_overflows = 0;
   int          idle_cycles = 0;
   postfix_type got;
   postfix_type want;

   infix_to_postfix_converter #(
      .STACK_DEPTH(DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   function automatic logic [PREC_W-1:0] rank_of(logic [CODE_W-1:0] code, logic unary);
      if (unary) begin
         return (code == OP_ADD || code == OP_SUB) ? PREC_UNARY : PREC_NONE;
      end
      case (code)
         OP_ASSIGN:                  return PREC_ASSIGN;
         OP_ADD, OP_SUB:             return PREC_ADD;
         OP_MUL, OP_DIV:             return PREC_MUL;
         OP_GT, OP_GE, OP_LT, OP_LE: return PREC_REL;
         OP_EQ, OP_NE:               return PREC_EQUAL;
         OP_LAND, OP_LOR:            return PREC_LOGIC;
         default:                    return PREC_NONE;
      endcase
   endfunction

   function automatic postfix_type postfix_beat(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] op,
                                                logic unary, logic [TAG_W-1:0] operand);
      postfix_type p;
      p.kind    = kind;
      p.op      = op;
      p.unary   = unary;
      p.operand = operand;
      p.last    = 1'b0;
      return p;
   endfunction

   // shunting-yard step; record=0 only advances the state
   task automatic shunt_token(input token_type t, input bit record);
      postfix_type       outs [$];
      entry_type         e;
      logic              un;
      logic [PREC_W-1:0] r;
      if (t.cmd == CMD_END) begin
         if (shadow_err) begin
            outs = {outs, postfix_beat(OUT_ERROR, '0, 1'b0, '0)};
         end else begin
            while (shadow_depth > 0) begin
               shadow_depth--;
               e = shadow_stack[shadow_depth];
               outs = {outs, postfix_beat(OUT_OPERATOR, e.code, e.unary, '0)};
            end
            outs = {outs, postfix_beat(OUT_END, '0, 1'b0, '0)};
         end
         shadow_depth        = 0;
         shadow_err          = 1'b0;
         shadow_expect_unary = 1'b1;
      end else if (shadow_err) begin
         // dropped until the end command
      end else if (t.kind == KIND_OPERAND) begin
         outs = {outs, postfix_beat(OUT_OPERAND, '0, 1'b0, t.tag)};
         shadow_expect_unary = 1'b0;
      end else if (t.kind == KIND_BRACKET) begin
         shadow_err = 1'b1;
      end else begin
         un = shadow_expect_unary;
         if (!un) begin
            r = rank_of(t.code, 1'b0);
            while (shadow_depth > 0 &&
                   rank_of(shadow_stack[shadow_depth-1].code,
                           shadow_stack[shadow_depth-1].unary) >= r) begin
               shadow_depth--;
               e = shadow_stack[shadow_depth];
               outs = {outs, postfix_beat(OUT_OPERATOR, e.code, e.unary, '0)};
            end
         end
         if (shadow_depth >= DEPTH) begin
            shadow_err = 1'b1;
            n_overflows++;
         end else begin
            e.code  = t.code;
            e.unary = un;
            shadow_stack[shadow_depth] = e;
            shadow_depth++;
         end
         shadow_expect_unary = (t.kind == KIND_OPERATOR);
      end
      if (outs.size() > 0) begin
         outs[outs.size()-1].last = 1'b1;
      end
      if (record) begin
         foreach (outs[i]) begin
            postfix_expected = {postfix_expected, outs[i]};
         end
      end
   endtask

   task automatic send_beat(input token_type t, input bit record);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_TDATA_W-TAG_W-CODE_W){1'b0}}, t.tag, t.code};
      req_tuser  <= {t.kind, t.cmd};
      do @(posedge clock); while (!req_tready);
      shunt_token(t, record);
      beats_taken++;
      if (t.cmd == CMD_END) begin
         n_exprs++;
      end
   endtask

   task automatic send_tok(logic cmd, logic [KIND_W-1:0] kind, logic [CODE_W-1:0] code,
                           logic [TAG_W-1:0] tag);
      token_type t;
      t.cmd  = cmd;
      t.kind = kind;
      t.code = code;
      t.tag  = tag;
      send_beat(t, 1'b1);
   endtask

   task automatic wait_drained();
      if (postfix_expected.size() != 0) begin
         req_tvalid <= 1'b0;
         while (postfix_expected.size() != 0) @(posedge clock);
      end
   endtask

   function automatic logic [TAG_W-1:0] rand_tag();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         default: return TAG_W'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic logic [CODE_W-1:0] rand_code();
      if ($urandom_range(0, 9) == 0) begin
         return CODE_W'($urandom_range(13, 31));
      end
      return CODE_W'($urandom_range(0, 12));
   endfunction

   function automatic logic [CODE_W-1:0] prefix_code();
      if ($urandom_range(0, 4) == 0) begin
         return rand_code();
      end
      return $urandom_range(0, 1) ? OP_ADD : OP_SUB;
   endfunction

   task automatic send_operator(bit allow_special, logic [CODE_W-1:0] code);
      send_tok(CMD_TOKEN,
               (allow_special && $urandom_range(0, 6) == 0) ? KIND_SPECIAL : KIND_OPERATOR,
               code, rand_tag());
   endtask

   task automatic send_terms(int terms);
      for (int k = 0; k < terms; k++) begin
         if (k > 0) begin
            send_operator(1'b1, rand_code());
         end
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 3)) send_operator(1'b1, prefix_code());
         end
         send_tok(CMD_TOKEN, KIND_OPERAND, rand_code(), rand_tag());
      end
   endtask

   task automatic send_expression();
      int mode;
      int terms;
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
         terms = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
         send_terms(terms);
         send_tok(CMD_END, KIND_W'($urandom_range(0, 3)), rand_code(), rand_tag());
      end else if (mode < 78) begin
         // long prefix chains around the stack limit
         repeat ($urandom_range(DEPTH - 3, DEPTH + 2)) send_operator(1'b0, prefix_code());
         if ($urandom_range(0, 1)) begin
            send_tok(CMD_TOKEN, KIND_OPERAND, rand_code(), rand_tag());
         end
         send_tok(CMD_END, KIND_OPERAND, '0, '0);
      end else if (mode < 90) begin
         send_terms($urandom_range(0, 3));
         send_tok(CMD_TOKEN, KIND_BRACKET, rand_code(), rand_tag());
         repeat ($urandom_range(0, 3)) begin
            send_tok(CMD_TOKEN, KIND_W'($urandom_range(0, 3)), rand_code(), rand_tag());
         end
         send_tok(CMD_END, KIND_W'($urandom_range(0, 3)), rand_code(), rand_tag());
      end else begin
         repeat ($urandom_range(1, 8)) begin
            send_tok($urandom_range(0, 7) == 0, KIND_W'($urandom_range(0, 3)),
                     CODE_W'($urandom_range(0, 31)), rand_tag());
         end
      end
   endtask

   // result side: check each beat, random stall bursts
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind    = rsp_tuser[1:0];
         got.unary   = rsp_tuser[2];
         got.op      = rsp_tdata[4:0];
         got.operand = rsp_tdata[20:5];
         got.last    = rsp_tlast;
         if (postfix_expected.size() == 0) begin
            errors++;
            if (errors <= MAX_REPORTS) begin
               $display("%0t: unexpected beat kind=%0d op=%0d un=%0d tag=%h last=%0d",
                        $time, got.kind, got.op, got.unary, got.operand, got.last);
            end
         end else begin
            want = postfix_expected.pop_front();
            n_checked++;
            if (got.kind == OUT_ERROR) begin
               n_err_markers++;
            end
            if (got !== want) begin
               errors++;
               if (errors <= MAX_REPORTS) begin
                  $display("%0t: expected %0d/%0d/%0d/%h/%0d got %0d/%0d/%0d/%h/%0d",
                           $time, want.kind, want.op, want.unary, want.operand, want.last,
                           got.kind, got.op, got.unary, got.operand, got.last);
               end
            end
         end
      end
      if (calm) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("%0t: timeout, no beat moved for %0d cycles, %0d results still expected",
               $time, WATCHDOG_LIMIT, postfix_expected.size());
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      dir_rows = '{
         '{'{CMD_END,   KIND_OPERAND,  OP_ASSIGN, 16'h0000}, 1, CHK_ONE,
           '{OUT_END, 5'd0, 1'b0, 16'h0000, 1'b1}},
         '{'{CMD_TOKEN, KIND_OPERAND,  5'd31,     16'hFFFF}, 1, CHK_ONE,
           '{OUT_OPERAND, 5'd0, 1'b0, 16'hFFFF, 1'b1}},
         '{'{CMD_END,   KIND_BRACKET,  5'd31,     16'hFFFF}, 1, CHK_ONE,
           '{OUT_END, 5'd0, 1'b0, 16'h0000, 1'b1}},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'h0000}, 1, CHK_ONE,
           '{OUT_OPERAND, 5'd0, 1'b0, 16'h0000, 1'b1}},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_ADD,    16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'h5555}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_MUL,    16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'hAAAA}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_SUB,    16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_SUB,    16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_ADD,    16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'h1234}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_SPECIAL,  5'd31,     16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_MUL,    16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'h00FF}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_LOR,    16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_ASSIGN, 16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'hFF00}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_ASSIGN, 16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'h8001}, 1, CHK_PREDICT, '0},
         '{'{CMD_END,   KIND_OPERAND,  OP_ASSIGN, 16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_SPECIAL,  5'd13,     16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_BRACKET,  OP_ASSIGN, 16'h0000}, 1, CHK_SILENT,  '0},
         '{'{CMD_TOKEN, KIND_OPERAND,  OP_ASSIGN, 16'h7777}, 1, CHK_SILENT,  '0},
         '{'{CMD_END,   KIND_OPERAND,  OP_ASSIGN, 16'h0000}, 1, CHK_ONE,
           '{OUT_ERROR, 5'd0, 1'b0, 16'h0000, 1'b1}},
         // full stack, then one push too many
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_ADD,    16'h0000}, DEPTH, CHK_PREDICT, '0},
         '{'{CMD_END,   KIND_OPERAND,  OP_ASSIGN, 16'h0000}, 1, CHK_PREDICT, '0},
         '{'{CMD_TOKEN, KIND_OPERATOR, OP_SUB,    16'h0000}, DEPTH + 1, CHK_PREDICT, '0},
         '{'{CMD_END,   KIND_OPERAND,  OP_ASSIGN, 16'h0000}, 1, CHK_ONE,
           '{OUT_ERROR, 5'd0, 1'b0, 16'h0000, 1'b1}}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         repeat (dir_rows[i].reps) begin
            send_beat(dir_rows[i].tok, dir_rows[i].check == CHK_PREDICT);
         end
         if (dir_rows[i].check == CHK_ONE) begin
            postfix_expected = {postfix_expected, dir_rows[i].want};
         end
      end
      wait_drained();

      while (beats_taken < BEAT_TARGET) begin
         if (beats_taken > BEAT_TARGET * 85 / 100) begin
            calm = 1'b1;
         end
         if ($urandom_range(0, 19) == 0) begin
            wait_drained();
         end
         send_expression();
      end
      send_tok(CMD_END, KIND_OPERAND, '0, '0);
      req_tvalid <= 1'b0;
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d token beats over %0d end commands, %0d stack overflows,",
               beats_taken, n_exprs, n_overflows);
      $display("and %0d postfix beats checked, %0d of them error markers.",
               n_checked, n_err_markers);
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
